/* src/prl_pkg.sv */
// Shared types and constants for the path remaining length block.
// Used by prl_ctrl, prl_dp and path_remaining_length_unit.
package prl_pkg;

	localparam int CRD_W  = 32;
	localparam int SQ_W   = 65;
	localparam int ROOT_W = 33;
	localparam int LEN_W  = 48;
	localparam int IDX_W  = 9;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_ROOT,
		S_SEG,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RES_APPEND,
		RES_FULL,
		RES_EMPTY,
		RES_QUERY
	} res_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic query_start;
		logic scan_issue;
		logic root_push;
		logic seg_issue;
		logic out_load;
		res_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic addr_last;
		logic seg_none;
		logic busy;
	} sts_t;

endpackage

/* src/prl_dp.sv */
// Datapath: point memory, distance pipeline, pipelined square root, accumulator.
// Depends on prl_pkg; driven by prl_ctrl through cmd_t / sts_t.
module prl_dp #(
	parameter int POINTS = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prl_pkg::cmd_t                     cmd,
	output prl_pkg::sts_t                     sts,
	input  logic signed [prl_pkg::CRD_W-1:0]  pos_x,
	input  logic signed [prl_pkg::CRD_W-1:0]  pos_y,
	output logic [prl_pkg::LEN_W-1:0]         remaining_length,
	output logic [prl_pkg::IDX_W-1:0]         nearest_index,
	output logic [1:0]                        status
);
	import prl_pkg::*;

	localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CW = $clog2(POINTS + 1);
	localparam int TW = SQ_W + 2;

	logic [CW-1:0]        count_q, addr_q;
	logic [2*CRD_W-1:0]   mem [POINTS];
	logic [2*CRD_W-1:0]   rd_a_q, rd_b_q;
	logic signed [CRD_W-1:0] qx_q, qy_q;
	logic                 rd_v_q, rd_seg_q;
	logic [AW-1:0]        rd_idx_q;
	logic [CW-1:0]        addr_prev;

	logic [CRD_W-1:0]     adx_s1, ady_s1;
	logic                 v_s1, seg_s1;
	logic [AW-1:0]        idx_s1;
	logic [2*CRD_W-1:0]   sqx_s2, sqy_s2;
	logic                 v_s2, seg_s2;
	logic [AW-1:0]        idx_s2;
	logic [SQ_W-1:0]      d_s3;
	logic                 v_s3, seg_s3;
	logic [AW-1:0]        idx_s3;

	logic [SQ_W-1:0]      best_d_q;
	logic [AW-1:0]        best_q;
	logic [LEN_W-1:0]     acc_q;

	logic                 sq_in_v;
	logic [SQ_W-1:0]      sq_in_val;
	logic [SQ_W-1:0]      sq_rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]    sq_root_s [1:ROOT_W];
	logic [ROOT_W-1:0]    sq_v_s;

	logic signed [CRD_W:0] dx, dy;
	logic [2*CRD_W-1:0]   opb;
	logic [LEN_W:0]       acc_sum;
	logic [31:0]          cnt_ext, best_ext;

	assign sts.full      = (count_q == CW'(POINTS));
	assign sts.empty     = (count_q == '0);
	assign sts.addr_last = (addr_q == CW'(count_q - CW'(1)));
	assign sts.seg_none  = (CW'(CW'(best_q) + CW'(1)) == count_q);
	assign sts.busy      = rd_v_q | v_s1 | v_s2 | v_s3 | (|sq_v_s);

	assign addr_prev = CW'(addr_q - CW'(1));

	// count and address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			addr_q   <= '0;
			rd_v_q   <= 1'b0;
			rd_seg_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append && !sts.full) begin
				count_q <= CW'(count_q + CW'(1));
			end
			if (cmd.query_start) begin
				addr_q <= '0;
			end else if (cmd.root_push) begin
				addr_q <= CW'(CW'(best_q) + CW'(1));
			end else if (cmd.scan_issue || cmd.seg_issue) begin
				addr_q <= CW'(addr_q + CW'(1));
			end
			rd_v_q   <= cmd.scan_issue | cmd.seg_issue;
			rd_seg_q <= cmd.seg_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !sts.full) begin
			mem[count_q[AW-1:0]] <= {pos_x, pos_y};
		end
		rd_a_q   <= mem[addr_q[AW-1:0]];
		rd_b_q   <= mem[addr_prev[AW-1:0]];
		rd_idx_q <= addr_q[AW-1:0];
		if (cmd.query_start) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
		end
	end

	// distance pipeline: difference, square, sum
	assign opb = rd_seg_q ? rd_b_q : {qx_q, qy_q};
	assign dx  = {rd_a_q[2*CRD_W-1], rd_a_q[2*CRD_W-1:CRD_W]}
	           - {opb[2*CRD_W-1], opb[2*CRD_W-1:CRD_W]};
	assign dy  = {rd_a_q[CRD_W-1], rd_a_q[CRD_W-1:0]} - {opb[CRD_W-1], opb[CRD_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_v_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		adx_s1 <= dx[CRD_W] ? CRD_W'(-dx) : CRD_W'(dx);
		ady_s1 <= dy[CRD_W] ? CRD_W'(-dy) : CRD_W'(dy);
		seg_s1 <= rd_seg_q;
		idx_s1 <= rd_idx_q;
		sqx_s2 <= adx_s1 * adx_s1;
		sqy_s2 <= ady_s1 * ady_s1;
		seg_s2 <= seg_s1;
		idx_s2 <= idx_s1;
		d_s3   <= SQ_W'(sqx_s2) + SQ_W'(sqy_s2);
		seg_s3 <= seg_s2;
		idx_s3 <= idx_s2;
		// keep the first point at the least distance
		if (v_s3 && !seg_s3 && (idx_s3 == '0 || d_s3 < best_d_q)) begin
			best_d_q <= d_s3;
			best_q   <= idx_s3;
		end
	end

	// square root, one result bit per stage
	assign sq_in_v   = cmd.root_push | (v_s3 & seg_s3);
	assign sq_in_val = cmd.root_push ? best_d_q : d_s3;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
		localparam int B = ROOT_W - 1 - k;
		logic [SQ_W-1:0]   rem_in;
		logic [ROOT_W-1:0] root_in;
		logic              v_in;
		logic [TW-1:0]     trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in  = sq_in_val;
			assign root_in = '0;
			assign v_in    = sq_in_v;
		end else begin : g_next
			assign rem_in  = sq_rem_s[k];
			assign root_in = sq_root_s[k];
			assign v_in    = sq_v_s[k-1];
		end

		assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
		assign take  = (TW'(rem_in) >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else begin
				sq_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k+1]  <= take ? SQ_W'(TW'(rem_in) - trial) : rem_in;
			sq_root_s[k+1] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
		end
	end

	assign acc_sum = (LEN_W+1)'(acc_q) + (LEN_W+1)'(sq_root_s[ROOT_W]);

	always_ff @(posedge clk) begin
		if (cmd.root_push) begin
			acc_q <= '0;
		end else if (sq_v_s[ROOT_W-1]) begin
			acc_q <= acc_sum[LEN_W] ? LEN_MAX : acc_sum[LEN_W-1:0];
		end
	end

	// result register
	assign cnt_ext  = 32'(count_q);
	assign best_ext = 32'(best_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_kind)
				RES_APPEND: begin
					remaining_length <= '0;
					nearest_index    <= cnt_ext[IDX_W-1:0];
					status           <= STS_OK;
				end
				RES_FULL: begin
					remaining_length <= '0;
					nearest_index    <= '0;
					status           <= STS_FULL;
				end
				RES_EMPTY: begin
					remaining_length <= '0;
					nearest_index    <= '0;
					status           <= STS_EMPTY;
				end
				default: begin
					remaining_length <= acc_q;
					nearest_index    <= best_ext[IDX_W-1:0];
					status           <= STS_OK;
				end
			endcase
		end
	end

endmodule

/* src/prl_ctrl.sv */
// Controller state machine: handshakes and sequencing of the query passes.
// Depends on prl_pkg; commands prl_dp through cmd_t, reads sts_t.
module prl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    operation,
	output logic          out_valid,
	input  logic          out_stall,
	input  prl_pkg::sts_t sts,
	output prl_pkg::cmd_t cmd
);
	import prl_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == S_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && op_t'(operation) == OP_QUERY && !sts.empty) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.addr_last) begin
					state_d = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: begin
				if (!sts.busy) begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				state_d = sts.seg_none ? S_DRAIN : S_SEG;
			end
			S_SEG: begin
				if (sts.addr_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_kind = RES_QUERY;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(operation))
						OP_CLEAR: cmd.clear = 1'b1;
						OP_APPEND: begin
							cmd.append   = 1'b1;
							cmd.out_load = 1'b1;
							cmd.res_kind = sts.full ? RES_FULL : RES_APPEND;
						end
						OP_QUERY: begin
							if (sts.empty) begin
								cmd.out_load = 1'b1;
								cmd.res_kind = RES_EMPTY;
							end else begin
								cmd.query_start = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN:  cmd.scan_issue = 1'b1;
			S_ROOT:  cmd.root_push  = 1'b1;
			S_SEG:   cmd.seg_issue  = 1'b1;
			S_DONE:  cmd.out_load   = out_free;
			default: ;
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over a pending item");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("query finished without presenting a result");

	a_root_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> !sts.busy)
		else $error("root pass started with scan still in flight");

endmodule

/* src/path_remaining_length_unit.sv */
// Top level of the path remaining length block.
// Depends on prl_pkg, prl_ctrl and prl_dp.
//
// Input channel (in_valid / in_stall): operation, pos_x, pos_y. Clear gives
// no item; append stores the point unless the path is full and gives one
// item; a query on an empty path gives one item with empty status.
// A query on n stored points reads the point memory once per point to find
// the nearest one and lets the distance pipeline drain, then reads one
// segment per cycle from that point to the end, feeding a 33-stage square
// root pipeline. The block takes one item at a time; the next item is
// accepted only once the controller is idle and the previous result has
// left or is leaving the output register.
// Output channel (out_valid / out_stall): remaining_length, nearest_index,
// status. The result register holds while out_stall is high, and a new item
// is taken only when that register is free or being emptied.
// Reset (arst_n low) empties the path and drops any pending result; point
// storage is not cleared and needs no sweep.
module path_remaining_length_unit #(
	parameter int POINTS = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic signed [prl_pkg::CRD_W-1:0]  pos_x,
	input  logic signed [prl_pkg::CRD_W-1:0]  pos_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [prl_pkg::LEN_W-1:0]         remaining_length,
	output logic [prl_pkg::IDX_W-1:0]         nearest_index,
	output logic [1:0]                        status
);
	import prl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	prl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	prl_dp #(
		.POINTS (POINTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.remaining_length (remaining_length),
		.nearest_index    (nearest_index),
		.status           (status)
	);

endmodule
